### rtl/smma_pkg.sv
// Package: shared types and codes for the sparse matrix merge-add block.
`timescale 1ns / 1ps
package smma_pkg;

    localparam int IDX_W      = 16;
    localparam int VAL_W      = 32;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MERGE  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_ENTRY    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISMATCH = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_A = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_B = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_B = 2'd3;

    localparam logic [CFG_DATA_W-1:0] DIM_RESET = 17'h10000;

    typedef enum logic [1:0] {
        KIND_LOAD_A,
        KIND_LOAD_B,
        KIND_MERGE
    } t_kind;

    typedef struct packed {
        logic  valid;
        t_kind kind;
    } t_q_head;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRIME,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic pop;
        logic we_a;
        logic we_b;
        logic set_ovf;
        logic emit;
        logic special;
        logic clear;
    } t_ctl;

endpackage

### rtl/smma_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module smma_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/smma_front.sv
// Front end: accepts items, classifies commands and queues them for the back end.
`timescale 1ns / 1ps
module smma_front #(
    parameter int INDEX_BITS = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [smma_pkg::CMD_W-1:0]    i_cmd,
    input  logic [smma_pkg::IDX_W-1:0]    i_row,
    input  logic [smma_pkg::IDX_W-1:0]    i_col,
    input  logic signed [smma_pkg::VAL_W-1:0] i_value,
    output smma_pkg::t_q_head             o_head,
    output logic [INDEX_BITS-1:0]         o_q_row,
    output logic [INDEX_BITS-1:0]         o_q_col,
    output logic [VALUE_BITS-1:0]         o_q_value,
    input  logic                          i_pop
);
    import smma_pkg::*;

    t_kind                 r_kind  [2];
    logic [INDEX_BITS-1:0] r_row   [2];
    logic [INDEX_BITS-1:0] r_col   [2];
    logic [VALUE_BITS-1:0] r_value [2];
    logic                  r_wr_ptr;
    logic                  r_rd_ptr;
    logic [1:0]            r_count;

    logic  w_accept;
    logic  w_push;
    logic  w_do_pop;
    t_kind w_kind;

    assign o_stall  = (r_count == 2'd2);
    assign w_accept = i_valid && !o_stall;

    always_comb begin
        w_kind = KIND_MERGE;
        w_push = 1'b0;
        unique case (i_cmd)
            CMD_LOAD_A: begin
                w_kind = KIND_LOAD_A;
                w_push = w_accept;
            end
            CMD_LOAD_B: begin
                w_kind = KIND_LOAD_B;
                w_push = w_accept;
            end
            CMD_MERGE: begin
                w_kind = KIND_MERGE;
                w_push = w_accept;
            end
            CMD_NONE: begin
                w_push = 1'b0;
            end
        endcase
    end

    assign w_do_pop = i_pop && (r_count != 2'd0);

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_kind[r_wr_ptr]  <= w_kind;
            r_row[r_wr_ptr]   <= i_row[INDEX_BITS-1:0];
            r_col[r_wr_ptr]   <= i_col[INDEX_BITS-1:0];
            r_value[r_wr_ptr] <= i_value[VALUE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'(w_push) - 2'(w_do_pop);
        end
    end

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.kind  = r_kind[r_rd_ptr];
    assign o_q_row      = r_row[r_rd_ptr];
    assign o_q_col      = r_col[r_rd_ptr];
    assign o_q_value    = r_value[r_rd_ptr];
endmodule

### rtl/smma_back.sv
// Back end: list storage, merge engine, dimension registers and output register.
`timescale 1ns / 1ps
module smma_back #(
    parameter int LIST_DEPTH = 32,
    parameter int INDEX_BITS = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [smma_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [smma_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  smma_pkg::t_q_head                i_head,
    input  logic [INDEX_BITS-1:0]            i_q_row,
    input  logic [INDEX_BITS-1:0]            i_q_col,
    input  logic [VALUE_BITS-1:0]            i_q_value,
    output logic                             o_pop,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [smma_pkg::STATUS_W-1:0]    o_status,
    output logic [smma_pkg::IDX_W-1:0]       o_out_row,
    output logic [smma_pkg::IDX_W-1:0]       o_out_col,
    output logic signed [smma_pkg::VAL_W-1:0] o_out_value,
    output logic                             o_dropped,
    output logic                             o_last
);
    import smma_pkg::*;

    localparam int AW    = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int EW    = 2 * INDEX_BITS + VALUE_BITS;

    logic [CFG_DATA_W-1:0] r_rows_a, r_cols_a, r_rows_b, r_cols_b;
    logic [CNT_W-1:0]      r_cnt_a, r_cnt_b;
    logic [CNT_W-1:0]      r_p, r_q;
    logic [CNT_W-1:0]      n_p, n_q;
    logic                  r_ovf;
    t_state                r_state, n_state;

    logic                  r_o_valid;
    logic [STATUS_W-1:0]   r_o_status;
    logic [IDX_W-1:0]      r_o_row, r_o_col;
    logic [VAL_W-1:0]      r_o_value;
    logic                  r_o_dropped, r_o_last;

    logic [EW-1:0]         w_rd_a, w_rd_b, w_wdata;
    logic [INDEX_BITS-1:0] w_a_row, w_a_col, w_b_row, w_b_col;
    logic [VALUE_BITS-1:0] w_a_val, w_b_val;
    logic                  w_a_ok, w_b_ok, w_a_lt, w_a_eq;
    logic                  w_adv_p, w_adv_q;
    logic [INDEX_BITS-1:0] w_sel_row, w_sel_col;
    logic [VALUE_BITS-1:0] w_sel_val;
    logic [CNT_W-1:0]      w_p_step, w_q_step;
    logic                  w_run_last;
    logic                  w_cfg_bad, w_empty, w_out_free, w_room_a, w_room_b;
    t_ctl                  w_ctl;

    assign w_wdata = {i_q_row, i_q_col, i_q_value};

    smma_ram #(.WIDTH(EW), .DEPTH(LIST_DEPTH)) u_list_a (
        .i_clk   (i_clk),
        .i_we    (w_ctl.we_a),
        .i_waddr (r_cnt_a[AW-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (n_p[AW-1:0]),
        .o_rdata (w_rd_a)
    );

    smma_ram #(.WIDTH(EW), .DEPTH(LIST_DEPTH)) u_list_b (
        .i_clk   (i_clk),
        .i_we    (w_ctl.we_b),
        .i_waddr (r_cnt_b[AW-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (n_q[AW-1:0]),
        .o_rdata (w_rd_b)
    );

    assign w_a_row = w_rd_a[EW-1 -: INDEX_BITS];
    assign w_a_col = w_rd_a[VALUE_BITS +: INDEX_BITS];
    assign w_a_val = w_rd_a[VALUE_BITS-1:0];
    assign w_b_row = w_rd_b[EW-1 -: INDEX_BITS];
    assign w_b_col = w_rd_b[VALUE_BITS +: INDEX_BITS];
    assign w_b_val = w_rd_b[VALUE_BITS-1:0];

    assign w_a_ok = (r_p < r_cnt_a);
    assign w_b_ok = (r_q < r_cnt_b);
    assign w_a_lt = ({w_a_row, w_a_col} < {w_b_row, w_b_col});
    assign w_a_eq = ({w_a_row, w_a_col} == {w_b_row, w_b_col});

    always_comb begin
        w_adv_p   = 1'b0;
        w_adv_q   = 1'b0;
        w_sel_row = w_a_row;
        w_sel_col = w_a_col;
        w_sel_val = w_a_val;
        priority if (w_a_ok && (!w_b_ok || w_a_lt)) begin
            w_adv_p = 1'b1;
        end else if (w_b_ok && (!w_a_ok || !w_a_eq)) begin
            w_adv_q   = 1'b1;
            w_sel_row = w_b_row;
            w_sel_col = w_b_col;
            w_sel_val = w_b_val;
        end else begin
            w_adv_p   = 1'b1;
            w_adv_q   = 1'b1;
            w_sel_val = VALUE_BITS'(w_a_val + w_b_val);
        end
    end

    assign w_p_step   = r_p + CNT_W'(w_adv_p);
    assign w_q_step   = r_q + CNT_W'(w_adv_q);
    assign w_run_last = (w_p_step == r_cnt_a) && (w_q_step == r_cnt_b);

    assign w_cfg_bad  = (r_rows_a != r_rows_b) || (r_cols_a != r_cols_b);
    assign w_empty    = (r_cnt_a == '0) && (r_cnt_b == '0);
    assign w_out_free = !r_o_valid || !i_stall;
    assign w_room_a   = (r_cnt_a < CNT_W'(LIST_DEPTH));
    assign w_room_b   = (r_cnt_b < CNT_W'(LIST_DEPTH));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_head.valid && (i_head.kind == KIND_MERGE) && !w_cfg_bad && !w_empty) begin
                    n_state = ST_PRIME;
                end
            end
            ST_PRIME: begin
                n_state = ST_RUN;
            end
            ST_RUN: begin
                if (w_out_free && w_run_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb begin
        w_ctl = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    unique case (i_head.kind)
                        KIND_LOAD_A: begin
                            w_ctl.pop     = 1'b1;
                            w_ctl.we_a    = w_room_a;
                            w_ctl.set_ovf = !w_room_a;
                        end
                        KIND_LOAD_B: begin
                            w_ctl.pop     = 1'b1;
                            w_ctl.we_b    = w_room_b;
                            w_ctl.set_ovf = !w_room_b;
                        end
                        KIND_MERGE: begin
                            if (w_cfg_bad || w_empty) begin
                                if (w_out_free) begin
                                    w_ctl.pop     = 1'b1;
                                    w_ctl.emit    = 1'b1;
                                    w_ctl.special = 1'b1;
                                    w_ctl.clear   = 1'b1;
                                end
                            end else begin
                                w_ctl.pop = 1'b1;
                            end
                        end
                        default: begin
                            w_ctl.pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_PRIME: begin
                w_ctl = '0;
            end
            ST_RUN: begin
                if (w_out_free) begin
                    w_ctl.emit  = 1'b1;
                    w_ctl.clear = w_run_last;
                end
            end
            default: begin
                w_ctl = '0;
            end
        endcase
    end

    always_comb begin
        n_p = r_p;
        n_q = r_q;
        if (w_ctl.clear) begin
            n_p = '0;
            n_q = '0;
        end else if ((r_state == ST_RUN) && w_ctl.emit) begin
            n_p = w_p_step;
            n_q = w_q_step;
        end
    end

    assign o_pop = w_ctl.pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_p       <= '0;
            r_q       <= '0;
            r_cnt_a   <= '0;
            r_cnt_b   <= '0;
            r_ovf     <= 1'b0;
            r_o_valid <= 1'b0;
            r_rows_a  <= DIM_RESET;
            r_cols_a  <= DIM_RESET;
            r_rows_b  <= DIM_RESET;
            r_cols_b  <= DIM_RESET;
        end else begin
            r_state <= n_state;
            r_p     <= n_p;
            r_q     <= n_q;
            if (w_ctl.clear) begin
                r_cnt_a <= '0;
                r_cnt_b <= '0;
                r_ovf   <= 1'b0;
            end else begin
                if (w_ctl.we_a) begin
                    r_cnt_a <= r_cnt_a + CNT_W'(1);
                end
                if (w_ctl.we_b) begin
                    r_cnt_b <= r_cnt_b + CNT_W'(1);
                end
                if (w_ctl.set_ovf) begin
                    r_ovf <= 1'b1;
                end
            end
            if (w_ctl.emit) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_ROWS_A: r_rows_a <= i_cfg_data;
                    REG_COLS_A: r_cols_a <= i_cfg_data;
                    REG_ROWS_B: r_rows_b <= i_cfg_data;
                    REG_COLS_B: r_cols_b <= i_cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.emit) begin
            r_o_dropped <= r_ovf;
            if (w_ctl.special) begin
                r_o_status <= w_cfg_bad ? STATUS_MISMATCH : STATUS_EMPTY;
                r_o_row    <= '0;
                r_o_col    <= '0;
                r_o_value  <= '0;
                r_o_last   <= 1'b1;
            end else begin
                r_o_status <= STATUS_ENTRY;
                r_o_row    <= IDX_W'(w_sel_row);
                r_o_col    <= IDX_W'(w_sel_col);
                r_o_value  <= VAL_W'($signed(w_sel_val));
                r_o_last   <= w_run_last;
            end
        end
    end

    assign o_valid     = r_o_valid;
    assign o_status    = r_o_status;
    assign o_out_row   = r_o_row;
    assign o_out_col   = r_o_col;
    assign o_out_value = r_o_value;
    assign o_dropped   = r_o_dropped;
    assign o_last      = r_o_last;
endmodule

### rtl/sparse_matrix_merge_add.sv
// Load items pass through a two-entry command queue, one item per cycle while it is not full.
// A merge leaves the queue, primes the list RAM reads, then emits one merged entry per cycle
// unless the output stalls (the registered RAM read feeds the compare/add step).
// Mismatch/empty results are registered when the merge heads the queue and the output is free.
// Synchronous active-low reset empties the queue and lists and sets all dimensions to 65536.
`timescale 1ns / 1ps
module sparse_matrix_merge_add #(
    parameter int LIST_DEPTH = 32,
    parameter int INDEX_BITS = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [smma_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [smma_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [smma_pkg::CMD_W-1:0]         i_cmd,
    input  logic [smma_pkg::IDX_W-1:0]         i_row,
    input  logic [smma_pkg::IDX_W-1:0]         i_col,
    input  logic signed [smma_pkg::VAL_W-1:0]  i_value,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [smma_pkg::STATUS_W-1:0]      o_status,
    output logic [smma_pkg::IDX_W-1:0]         o_out_row,
    output logic [smma_pkg::IDX_W-1:0]         o_out_col,
    output logic signed [smma_pkg::VAL_W-1:0]  o_out_value,
    output logic                               o_dropped,
    output logic                               o_last
);
    import smma_pkg::*;

    t_q_head               w_head;
    logic [INDEX_BITS-1:0] w_q_row, w_q_col;
    logic [VALUE_BITS-1:0] w_q_value;
    logic                  w_pop;

    smma_front #(
        .INDEX_BITS (INDEX_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_cmd     (i_cmd),
        .i_row     (i_row),
        .i_col     (i_col),
        .i_value   (i_value),
        .o_head    (w_head),
        .o_q_row   (w_q_row),
        .o_q_col   (w_q_col),
        .o_q_value (w_q_value),
        .i_pop     (w_pop)
    );

    smma_back #(
        .LIST_DEPTH (LIST_DEPTH),
        .INDEX_BITS (INDEX_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_head      (w_head),
        .i_q_row     (w_q_row),
        .i_q_col     (w_q_col),
        .i_q_value   (w_q_value),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_status    (o_status),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_out_value (o_out_value),
        .o_dropped   (o_dropped),
        .o_last      (o_last)
    );
endmodule
